### rtl/core/selective_reject_receiver_macros.svh
// assertion helpers used by the checker file
`ifndef SELECTIVE_REJECT_RECEIVER_MACROS_SVH
`define SELECTIVE_REJECT_RECEIVER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SRR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/srr_pkg.sv
package srr_pkg;

    localparam int SEQ_W          = 32;
    localparam int FLAG_W         = 8;
    localparam int ACT_W          = 3;
    localparam int WS_W           = 5;
    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [WS_W-1:0]   WS_RESET    = 5'd16;

    localparam logic [FLAG_W-1:0] FLAG_EOF    = 8'd10;
    localparam logic [FLAG_W-1:0] FLAG_DATA_A = 8'd16;
    localparam logic [FLAG_W-1:0] FLAG_DATA_B = 8'd17;
    localparam logic [FLAG_W-1:0] FLAG_DATA_C = 8'd18;

    typedef enum logic [ACT_W-1:0] {
        ACT_DELIVER_IN   = 3'd0,
        ACT_STORE        = 3'd1,
        ACT_DELIVER_SLOT = 3'd2,
        ACT_RR           = 3'd3,
        ACT_SREJ         = 3'd4,
        ACT_EOF_ACK      = 3'd5
    } action_t;

endpackage

### rtl/core/selective_reject_receiver.sv
// in-order data header: busy through the decode and ack states; deliver result from decode, ready from ack
// early data header: busy through decode, the 32-step bit-serial modulo unit, store and, for a first gap, reject
// gap-filling header / end of file: decode, modulo unit, then one drain step per delivered slot (at most MAX_WINDOW)
// a new transaction is taken in the first idle cycle after busy drops; at most one result per cycle
// results are strobed for one cycle and cannot be stalled by the receiver side
// async active-low reset: window 16, next expected 1, highest seen 0, all slots empty
module selective_reject_receiver
    import srr_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SEQ_W-1:0]  seq_num,
    input  logic [FLAG_W-1:0] packet_flag,
    input  logic              window_size_we,
    input  logic [WS_W-1:0]   window_size,
    output logic              busy,
    output logic              action_valid,
    output logic [ACT_W-1:0]  action
);

    // slot index, effective window and helper widths
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int EW     = (WIN_W > WS_W) ? WIN_W : WS_W;
    localparam int CNT_W  = $clog2(SEQ_W);
    localparam int STEP_W = $clog2(MAX_WINDOW + 1);

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_MOD    = 7'b0000100,
        S_STORE  = 7'b0001000,
        S_SREJ   = 7'b0010000,
        S_RR     = 7'b0100000,
        S_DRAIN  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [WS_W-1:0]     ws_reg, ws_next;
    logic [SEQ_W-1:0]    ne_reg, ne_next;          // next expected sequence number
    logic [SEQ_W-1:0]    hs_reg, hs_next;          // highest sequence number seen
    logic                slot_valid_reg [MAX_WINDOW];
    logic                slot_valid_next [MAX_WINDOW];
    logic                reorder_reg, reorder_next;
    logic                finished_reg, finished_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;        // header seq, then modulo dividend
    logic [FLAG_W-1:0]   flag_reg, flag_next;
    logic [WIN_W-1:0]    rem_reg, rem_next;        // modulo remainder, then walking slot
    logic [CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                srej_pend_reg, srej_pend_next;
    logic                mod_store_reg, mod_store_next;
    action_t             act_reg, act_next;
    logic                act_vld_reg, act_vld_next;

    logic [EW-1:0]       ws_ext;
    logic [EW-1:0]       weff_ext;
    logic [WIN_W-1:0]    win_eff;
    logic [WIN_W:0]      trial;
    logic [WIN_W-1:0]    rem_step;
    logic [WIN_W:0]      slot_inc;
    logic [WIN_W-1:0]    slot_adv;
    logic [SEQ_W-1:0]    ne_inc;
    logic [SLOT_W-1:0]   cur_slot;
    logic                is_data;
    logic                drain_go;

    // effective window: zero reads as one, clamp to the slot count
    always_comb
    begin
        ws_ext = EW'(ws_reg);
        if (ws_ext == '0)
        begin
            weff_ext = EW'(1);
        end
        else if (ws_ext > EW'(MAX_WINDOW))
        begin
            weff_ext = EW'(MAX_WINDOW);
        end
        else
        begin
            weff_ext = ws_ext;
        end
        win_eff = weff_ext[WIN_W-1:0];
    end

    // shared compare/subtract unit: one remainder bit per cycle, msb first
    always_comb
    begin
        trial = {rem_reg, seq_reg[SEQ_W-1]};
        if (trial >= {1'b0, win_eff})
        begin
            rem_step = WIN_W'(trial - {1'b0, win_eff});
        end
        else
        begin
            rem_step = trial[WIN_W-1:0];
        end
    end

    // slot of next_expected + 1, wrapping to zero at the window end and forced to zero when the sequence number wraps
    assign ne_inc   = ne_reg + SEQ_W'(1);
    assign slot_inc = {1'b0, rem_reg} + (WIN_W + 1)'(1);
    assign slot_adv = ((ne_inc == '0) || (slot_inc == {1'b0, win_eff})) ?
                      '0 : slot_inc[WIN_W-1:0];
    assign cur_slot = rem_reg[SLOT_W-1:0];

    assign is_data  = (flag_reg == FLAG_DATA_A) || (flag_reg == FLAG_DATA_B) ||
                      (flag_reg == FLAG_DATA_C);

    // flush walk goes on while the next expected slot is filled, up to the highest seen and MAX_WINDOW steps
    assign drain_go = (step_reg != STEP_W'(MAX_WINDOW)) && (ne_reg <= hs_reg) &&
                      slot_valid_reg[cur_slot];

    always_comb
    begin
        state_next      = state_reg;
        ws_next         = window_size_we ? window_size : ws_reg;
        ne_next         = ne_reg;
        hs_next         = hs_reg;
        slot_valid_next = slot_valid_reg;
        reorder_next    = reorder_reg;
        finished_next   = finished_reg;
        seq_next        = seq_reg;
        flag_next       = flag_reg;
        rem_next        = rem_reg;
        bit_cnt_next    = bit_cnt_reg;
        step_next       = step_reg;
        srej_pend_next  = srej_pend_reg;
        mod_store_next  = mod_store_reg;
        act_next        = act_reg;
        act_vld_next    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    seq_next   = seq_num;
                    flag_next  = packet_flag;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                rem_next       = '0;
                bit_cnt_next   = CNT_W'(SEQ_W - 1);
                step_next      = '0;
                srej_pend_next = 1'b0;
                state_next     = S_IDLE;
                if (!finished_reg)
                begin
                    if (flag_reg == FLAG_EOF)
                    begin
                        // flush from the current expected number
                        seq_next       = ne_reg;
                        mod_store_next = 1'b0;
                        state_next     = S_MOD;
                    end
                    else if (is_data)
                    begin
                        if (seq_reg == ne_reg)
                        begin
                            act_next     = ACT_DELIVER_IN;
                            act_vld_next = 1'b1;
                            ne_next      = ne_inc;
                            if (!reorder_reg)
                            begin
                                hs_next    = seq_reg;
                                state_next = S_RR;
                            end
                            else
                            begin
                                // gap filled: find the slot of the new expected number
                                seq_next       = ne_inc;
                                mod_store_next = 1'b0;
                                state_next     = S_MOD;
                            end
                        end
                        else if (seq_reg > ne_reg)
                        begin
                            if (seq_reg > hs_reg)
                            begin
                                hs_next = seq_reg;
                            end
                            srej_pend_next = !reorder_reg;
                            reorder_next   = 1'b1;
                            mod_store_next = 1'b1;
                            state_next     = S_MOD;
                        end
                    end
                end
            end

            S_MOD:
            begin
                seq_next     = {seq_reg[SEQ_W-2:0], 1'b0};
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    state_next = mod_store_reg ? S_STORE : S_DRAIN;
                end
            end

            S_STORE:
            begin
                slot_valid_next[cur_slot] = 1'b1;
                act_next     = ACT_STORE;
                act_vld_next = 1'b1;
                state_next   = srej_pend_reg ? S_SREJ : S_IDLE;
            end

            S_SREJ:
            begin
                act_next     = ACT_SREJ;
                act_vld_next = 1'b1;
                state_next   = S_IDLE;
            end

            S_RR:
            begin
                act_next     = ACT_RR;
                act_vld_next = 1'b1;
                state_next   = S_IDLE;
            end

            S_DRAIN:
            begin
                act_vld_next = 1'b1;
                if (drain_go)
                begin
                    slot_valid_next[cur_slot] = 1'b0;
                    act_next  = ACT_DELIVER_SLOT;
                    ne_next   = ne_inc;
                    rem_next  = slot_adv;
                    step_next = step_reg + STEP_W'(1);
                end
                else
                begin
                    state_next = S_IDLE;
                    if (flag_reg == FLAG_EOF)
                    begin
                        act_next      = ACT_EOF_ACK;
                        finished_next = 1'b1;
                    end
                    else if (ne_reg <= hs_reg)
                    begin
                        act_next = ACT_SREJ;
                    end
                    else
                    begin
                        act_next     = ACT_RR;
                        reorder_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ws_reg         <= WS_RESET;
            ne_reg         <= SEQ_W'(1);
            hs_reg         <= '0;
            slot_valid_reg <= '{default: 1'b0};
            reorder_reg    <= 1'b0;
            finished_reg   <= 1'b0;
            act_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ws_reg         <= ws_next;
            ne_reg         <= ne_next;
            hs_reg         <= hs_next;
            slot_valid_reg <= slot_valid_next;
            reorder_reg    <= reorder_next;
            finished_reg   <= finished_next;
            act_vld_reg    <= act_vld_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        seq_reg       <= seq_next;
        flag_reg      <= flag_next;
        rem_reg       <= rem_next;
        bit_cnt_reg   <= bit_cnt_next;
        step_reg      <= step_next;
        srej_pend_reg <= srej_pend_next;
        mod_store_reg <= mod_store_next;
        act_reg       <= act_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign action_valid = act_vld_reg;
    assign action       = act_reg;

endmodule

### rtl/core/srr_checker.sv
`include "selective_reject_receiver_macros.svh"

module srr_checker
    import srr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             action_valid,
    input logic [ACT_W-1:0] action
);

    // only defined action codes leave the block
    `SRR_ASSERT_SAME(a_action_code, action_valid, action <= ACT_EOF_ACK, "undefined action code")

    // an accepted transaction always occupies the sequencer
    `SRR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")

    // busy only rises from an accepted transaction
    `SRR_ASSERT_SAME(a_busy_cause, $rose(busy), $past(start), "busy without a start")

    // the end ack is the last result of its transaction and nothing follows it
    `SRR_ASSERT_NEXT(a_eof_last, action_valid && (action == ACT_EOF_ACK), !action_valid, "result after end ack")

endmodule

bind selective_reject_receiver srr_checker u_srr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action_valid (action_valid),
    .action       (action)
);

### sim/tb_selective_reject_receiver.sv
`timescale 1ns / 100ps

module tb_selective_reject_receiver;
    import srr_pkg::*;

    localparam int MAX_WIN          = MAX_WINDOW_DEF;
    // longest busy stretch covers decode, the modulo unit and one drain step per flushed slot
    localparam int SETTLE_CYCLES    = 64;
    localparam int SHOWN_MISMATCHES = 10;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic [SEQ_W-1:0]  seq_num;
    logic [FLAG_W-1:0] packet_flag;
    logic              window_size_we;
    logic [WS_W-1:0]   window_size;
    logic              busy;
    logic              action_valid;
    logic [ACT_W-1:0]  action;

    // receiver state as the testbench expects it
    logic [WS_W-1:0]  win_reg;
    logic [SEQ_W-1:0] exp_next_seq;
    logic [SEQ_W-1:0] exp_highest;
    logic             slot_full [MAX_WIN];
    logic             in_reorder;
    logic             rx_done;

    // actions still owed by the receiver, oldest first
    action_t expected_actions [$];

    int gap_next;
    int burst_left;
    int mismatches;
    int actions_checked;
    int headers_sent;
    int windows_used;

    selective_reject_receiver i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .seq_num        (seq_num),
        .packet_flag    (packet_flag),
        .window_size_we (window_size_we),
        .window_size    (window_size),
        .busy           (busy),
        .action_valid   (action_valid),
        .action         (action)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case a transaction or an action never shows up
    initial
    begin
        #2_000_000;
        $display("tb_selective_reject_receiver: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // expected behavior
    // ------------------------------------------------------------------

    // register value 0 acts as 1, anything above the slot count is clamped
    function automatic int active_window();
        if (win_reg == '0)
            return 1;
        if (win_reg > MAX_WIN)
            return MAX_WIN;
        return int'(win_reg);
    endfunction

    function automatic int slot_of(input logic [SEQ_W-1:0] s);
        return int'(s % SEQ_W'(active_window()));
    endfunction

    function automatic bit is_data(input logic [FLAG_W-1:0] f);
        return f == FLAG_DATA_A || f == FLAG_DATA_B || f == FLAG_DATA_C;
    endfunction

    // hand over consecutive stored slots, bounded by the slot count
    function automatic void flush_slots();
        int step;
        int s;
        for (step = 0; step < MAX_WIN; step++)
        begin
            if (exp_next_seq > exp_highest)
                break;
            s = slot_of(exp_next_seq);
            if (!slot_full[s])
                break;
            slot_full[s] = 1'b0;
            expected_actions.push_back(ACT_DELIVER_SLOT);
            exp_next_seq = exp_next_seq + 1'b1;
        end
    endfunction

    // queue the actions one accepted header causes, returns how many
    function automatic int receive_header(input logic [SEQ_W-1:0] s,
                                          input logic [FLAG_W-1:0] f);
        int queued;
        queued = expected_actions.size();
        if (rx_done)
            return 0;
        if (f == FLAG_EOF)
        begin
            flush_slots();
            expected_actions.push_back(ACT_EOF_ACK);
            rx_done = 1'b1;
        end
        else if (is_data(f))
        begin
            if (s == exp_next_seq)
            begin
                expected_actions.push_back(ACT_DELIVER_IN);
                exp_next_seq = exp_next_seq + 1'b1;
                if (in_reorder)
                begin
                    flush_slots();
                    if (exp_next_seq <= exp_highest)
                        expected_actions.push_back(ACT_SREJ);
                    else
                    begin
                        expected_actions.push_back(ACT_RR);
                        in_reorder = 1'b0;
                    end
                end
                else
                begin
                    exp_highest = s;
                    expected_actions.push_back(ACT_RR);
                end
            end
            else if (s > exp_next_seq)
            begin
                // a collision just leaves the slot marked
                slot_full[slot_of(s)] = 1'b1;
                expected_actions.push_back(ACT_STORE);
                if (s > exp_highest)
                    exp_highest = s;
                // only the first early packet of a gap triggers a reject
                if (!in_reorder)
                begin
                    expected_actions.push_back(ACT_SREJ);
                    in_reorder = 1'b1;
                end
            end
            // stale numbers are dropped silently
        end
        return expected_actions.size() - queued;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // idle cycles before the next transaction, with runs of back-to-back ones
    function automatic int draw_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            burst_left = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [FLAG_W-1:0] data_flag();
        case ($urandom_range(0, 2))
            0:       return FLAG_DATA_A;
            1:       return FLAG_DATA_B;
            default: return FLAG_DATA_C;
        endcase
    endfunction

    // any flag the receiver has to ignore
    function automatic logic [FLAG_W-1:0] noise_flag();
        logic [FLAG_W-1:0] f;
        do
            f = FLAG_W'($urandom_range(0, 255));
        while (is_data(f) || f == FLAG_EOF);
        return f;
    endfunction

    // one header transaction; start stays high when the next one follows at once
    task automatic send_header(input logic [SEQ_W-1:0] s, input logic [FLAG_W-1:0] f,
                               output int n_actions);
        repeat (gap_next) @(posedge clk);
        start       <= 1'b1;
        seq_num     <= s;
        packet_flag <= f;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // taken at this edge
        n_actions = receive_header(s, f);
        headers_sent++;
        gap_next = draw_gap();
        if (gap_next != 0)
            start <= 1'b0;
    endtask

    // wait for all owed actions, then long enough for a silent header to finish
    task automatic settle();
        if (gap_next == 0)
            start <= 1'b0;
        while (expected_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [WS_W-1:0] v);
        settle();
        window_size_we <= 1'b1;
        window_size    <= v;
        @(posedge clk);
        window_size_we <= 1'b0;
        win_reg = v;
        windows_used++;
    endtask

    // ------------------------------------------------------------------
    // result checking, one action per strobe
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        action_t want;
        if (rst_n && action_valid)
        begin
            if (expected_actions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("%0t: action %0d with nothing outstanding", $realtime, action);
            end
            else
            begin
                want = expected_actions.pop_front();
                actions_checked++;
                if (action !== want)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display("%0t: action expected %s (%0d), got %0d",
                                 $realtime, want.name(), want, action);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset window of 16, next expected 1
    task automatic test_basic_ordering();
        int n;
        send_header(32'd1, FLAG_DATA_A, n);         // in order: deliver, ready
        send_header(32'd4, FLAG_DATA_C, n);         // early: store, reject
        send_header(32'd3, FLAG_DATA_B, n);         // early while reordering: store only
        send_header(32'd0, FLAG_DATA_A, n);         // stale, dropped
        send_header(32'hFFFF_FFFF, 8'hFF, n);       // unknown flag, all bits set
        send_header(32'd7, 8'h00, n);               // unknown flag, all bits clear
        send_header(32'd2, FLAG_DATA_B, n);         // gap filled: deliver, flush 3 and 4, ready
    endtask

    // small window so a stored packet's slot is aliased by a lower sequence number
    task automatic test_slot_collision();
        int n;
        logic [SEQ_W-1:0] base;
        write_window(5'd4);
        base = exp_next_seq;
        send_header(base + 32'd7, data_flag(), n);
        send_header(base + 32'd1, data_flag(), n);
        send_header(base, data_flag(), n);          // flushes one slot, hole left
        send_header(base + 32'd2, data_flag(), n);  // aliased slot gets flushed too
    endtask

    // every slot full so one header flushes the whole window
    task automatic test_full_flush();
        int n;
        int k;
        logic [SEQ_W-1:0] base;
        write_window(5'd16);
        base = exp_next_seq;
        for (k = 1; k <= MAX_WIN; k++)
            send_header(base + SEQ_W'(k), data_flag(), n);
        send_header(base, data_flag(), n);
    endtask

    // mostly well-formed traffic around the expected number
    task automatic test_random_traffic(input logic [WS_W-1:0] w, input int budget);
        int n;
        int r;
        int done;
        logic [SEQ_W-1:0] s;
        logic [FLAG_W-1:0] f;
        write_window(w);
        done = 0;
        while (done < budget)
        begin
            r = $urandom_range(0, 99);
            f = data_flag();
            if (r < 45)
                s = exp_next_seq;
            else if (r < 60 && in_reorder && exp_highest > exp_next_seq)
                s = exp_next_seq + $urandom_range(1, exp_highest - exp_next_seq);
            else if (r < 80)
                s = exp_next_seq + $urandom_range(1, 2 * active_window() + 2);
            else if (r < 88)
                s = (exp_next_seq > 4) ? exp_next_seq - $urandom_range(1, 4) : '0;
            else
            begin
                s = $urandom();
                f = noise_flag();
            end
            send_header(s, f, n);
            done++;
        end
    endtask

    // full-range sequence numbers; leaves the receiver reordering for good
    task automatic test_wide_sequence_numbers();
        int n;
        int k;
        write_window(5'd16);
        send_header(32'hFFFF_FFFF, data_flag(), n);
        for (k = 0; k < 24; k++)
        begin
            if ($urandom_range(0, 9) < 7)
                send_header($urandom(), data_flag(), n);
            else
                send_header(exp_next_seq, data_flag(), n);
        end
    endtask

    // end of file flushes what is stored, then everything is ignored
    task automatic test_end_of_file();
        int n;
        logic [SEQ_W-1:0] base;
        settle();
        base = exp_next_seq;
        send_header(base + SEQ_W'(active_window()), data_flag(), n);  // lands in base's slot
        send_header(base + 32'd1, data_flag(), n);
        send_header($urandom(), FLAG_EOF, n);
        send_header(exp_next_seq, data_flag(), n);
        send_header($urandom(), FLAG_EOF, n);
        send_header($urandom(), noise_flag(), n);
    endtask

    // ------------------------------------------------------------------
    // sequence of tests
    // ------------------------------------------------------------------
    initial
    begin
        int guard;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        seq_num        <= '0;
        packet_flag    <= '0;
        window_size_we <= 1'b0;
        window_size    <= WS_RESET;

        win_reg      = WS_RESET;
        exp_next_seq = 32'd1;
        exp_highest  = '0;
        foreach (slot_full[i])
            slot_full[i] = 1'b0;
        in_reorder      = 1'b0;
        rx_done         = 1'b0;
        gap_next        = 0;
        burst_left      = 0;
        mismatches      = 0;
        actions_checked = 0;
        headers_sent    = 0;
        windows_used    = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ordering();
        test_slot_collision();
        test_full_flush();
        test_random_traffic(5'd1, 52);
        test_random_traffic(5'd0, 52);
        test_random_traffic(5'd31, 52);
        test_random_traffic(5'd4, 52);
        test_random_traffic(5'd16, 52);
        test_random_traffic(5'd9, 52);
        test_random_traffic(5'd2, 52);
        test_random_traffic(5'd16, 52);
        test_wide_sequence_numbers();
        test_end_of_file();

        // drain with a bound, then give a late action time to show up
        if (gap_next == 0)
            start <= 1'b0;
        guard = 0;
        while (expected_actions.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_actions.size() != 0)
        begin
            mismatches += expected_actions.size();
            $display("%0d expected actions never arrived", expected_actions.size());
        end

        $display("%0d headers sent, %0d actions checked across %0d window writes",
                 headers_sent, actions_checked, windows_used);
        $display("covered reordering, slot aliasing, full-window flush and end of file");
        if (mismatches == 0)
            $display("tb_selective_reject_receiver: clean");
        else
            $display("tb_selective_reject_receiver: errors");
        $finish;
    end

endmodule
